/* src/assert_macros.svh */
// Assertion macros for the swap search RTL.
// Depends on nothing; SYNTH removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define CHK_IMPL(lbl, clk, rst_n, a, c)
`define CHK_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

/* src/vrp_pkg.sv */
// Types and constants for the route swap search.
// Used by vrp_cfg, the top level and the testbench.
package vrp_pkg;
    localparam int MaxCities = 64;
    localparam int MaxRoute  = 64;
    localparam int DistWidth = 16;
    localparam int CityW     = 6;
    localparam int PosW      = 6;
    localparam int CostW     = 24;
    localparam logic [CostW-1:0] CostMax = '1;

    localparam logic [1:0] KIND_DIST  = 2'd0;
    localparam logic [1:0] KIND_DEM   = 2'd1;
    localparam logic [1:0] KIND_ROUTE = 2'd2;
    localparam logic [1:0] KIND_START = 2'd3;

    localparam logic [1:0] REG_CAP   = 2'd0;
    localparam logic [1:0] REG_LEN   = 2'd1;
    localparam logic [1:0] REG_DEPOT = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  first_index;
        logic [5:0]  second_index;
        logic [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  position;
        logic [5:0]  city;
        logic [23:0] total_cost;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [19:0] capacity;
        logic [6:0]  length;
        logic [5:0]  depot;
    } t_cfg;
endpackage

/* src/vrp_ram.sv */
// Generic single-port-write, one-read synchronous RAM, registered read.
// No dependencies.
module vrp_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* src/vrp_cfg.sv */
// APB register file for capacity, route length and depot city.
// Depends on vrp_pkg.
module vrp_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output vrp_pkg::t_cfg o_cfg
);
    import vrp_pkg::*;
    logic [19:0] r_cap;
    logic [6:0]  r_len;
    logic [5:0]  r_depot;
    logic        wr;
    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0; r_len <= '0; r_depot <= '0;
        end else if (wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                REG_CAP:   r_cap <= pwdata[19:0];
                REG_LEN:   r_len <= pwdata[6:0];
                REG_DEPOT: r_depot <= pwdata[5:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_CAP:   prdata = {12'd0, r_cap};
            REG_LEN:   prdata = {25'd0, r_len};
            REG_DEPOT: prdata = {26'd0, r_depot};
            default:   prdata = '0;
        endcase
    end
    assign o_cfg = '{capacity: r_cap, length: r_len, depot: r_depot};
endmodule

/* src/vrp_swap_local_search.sv */
// Top level: stores, swap search sequencer and result output.
// Depends on vrp_pkg, vrp_ram, vrp_cfg and assert_macros.svh.
//
//  channel | direction | handshake            | payload
//  in      | input     | i_valid / o_stall    | t_in_item
//  out     | output    | o_valid / i_stall    | t_out_item
//  cfg     | input     | psel/penable/pready  | 32-bit registers
//
// Load items are accepted one per cycle while the block is idle. A start runs
// the sequencer: the cost pass and every trial swap each walk the work route one
// entry per cycle through the distance and demand memory ports. Results then
// leave one per S_OUT/S_ORD pass, held while i_stall holds them. Synchronous
// active-low reset clears control state only. o_stall is high for the whole
// search and output phase.
`include "assert_macros.svh"
module vrp_swap_local_search (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  vrp_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output vrp_pkg::t_out_item o_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import vrp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_COPY  = 4'd1;
    localparam logic [3:0] S_CRD   = 4'd2;  // walk route, fetch distances
    localparam logic [3:0] S_CWAIT = 4'd3;
    localparam logic [3:0] S_SWAPA = 4'd4;
    localparam logic [3:0] S_SWAPB = 4'd5;
    localparam logic [3:0] S_LOAD  = 4'd6;  // capacity walk
    localparam logic [3:0] S_DEC   = 4'd7;
    localparam logic [3:0] S_NEXT  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_ORD   = 4'd10;
    localparam logic [3:0] S_SWAPR = 4'd11;
    localparam logic [3:0] S_SWAPW = 4'd12;
    localparam logic [3:0] S_LEND  = 4'd13;
    localparam logic [3:0] S_KEEP  = 4'd14;

    t_cfg cfg;
    vrp_cfg u_cfg (.i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
                   .prdata, .pready, .o_cfg(cfg));

    logic [3:0]  r_st;
    logic [6:0]  r_len;
    logic [5:0]  r_a, r_b;
    logic [6:0]  r_i;          // walk index
    logic        r_first;      // first cost pass (initial cost)
    logic [CostW-1:0] r_cost, r_trial, r_best;
    logic [20:0] r_load;
    logic        r_fail;
    logic [5:0]  r_prev;       // previous city in the walk
    logic        r_pend;       // a read issued last cycle is due now
    logic        r_cur_dep;
    logic [5:0]  r_ca, r_cb;
    logic        r_ovalid;
    t_out_item   r_odata;

    // memories
    logic        dist_we, dem_we, rt_we, wk_we;
    logic [11:0] dist_ra;
    logic [5:0]  dem_ra, rt_ra, wk_wa, wk_ra;
    logic [5:0]  wk_wd;
    logic [15:0] dist_rd, dem_rd;
    logic [5:0]  rt_rd, wk_rd;
    logic        acc;
    assign acc = i_valid && !o_stall;
    assign dist_we = acc && i_data.kind == KIND_DIST;
    assign dem_we  = acc && i_data.kind == KIND_DEM;
    assign rt_we   = acc && i_data.kind == KIND_ROUTE;

    vrp_ram #(.Width(16), .Depth(4096)) u_dist (.i_clk, .i_we(dist_we),
        .i_waddr({i_data.first_index, i_data.second_index}), .i_wdata(i_data.value),
        .i_raddr(dist_ra), .o_rdata(dist_rd));
    vrp_ram #(.Width(16), .Depth(64)) u_dem (.i_clk, .i_we(dem_we),
        .i_waddr(i_data.first_index), .i_wdata(i_data.value),
        .i_raddr(dem_ra), .o_rdata(dem_rd));
    vrp_ram #(.Width(6), .Depth(64)) u_rt (.i_clk, .i_we(rt_we),
        .i_waddr(i_data.first_index), .i_wdata(i_data.value[5:0]),
        .i_raddr(rt_ra), .o_rdata(rt_rd));
    vrp_ram #(.Width(6), .Depth(64)) u_wk (.i_clk, .i_we(wk_we),
        .i_waddr(wk_wa), .i_wdata(wk_wd), .i_raddr(wk_ra), .o_rdata(wk_rd));

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    logic [6:0] lastpos;
    assign lastpos = r_len - 7'd1;
    logic [CostW:0] csum;
    assign csum = {1'b0, r_trial} + {{(CostW-DistWidth+1){1'b0}}, dist_rd};
    logic [20:0] lsum;
    assign lsum = r_load + {5'd0, dem_rd};

    // combinational memory addressing
    always_comb begin
        rt_ra = r_i[5:0];
        wk_ra = r_i[5:0];
        wk_we = 1'b0; wk_wa = r_i[5:0]; wk_wd = rt_rd;
        dist_ra = {r_prev, wk_rd};
        dem_ra = wk_rd;
        unique case (r_st)
            S_COPY: begin
                wk_we = r_pend; wk_wa = r_i[5:0] - 6'd1;
            end
            S_SWAPA: begin
                wk_ra = r_b;
            end
            S_SWAPB: begin
                wk_we = 1'b1; wk_wa = r_a; wk_wd = wk_rd;  // work[a] <= old work[b]
            end
            S_SWAPW: begin
                wk_we = 1'b1; wk_wa = r_b; wk_wd = r_ca;   // work[b] <= old work[a]
            end
            S_NEXT: begin
                wk_we = 1'b1; wk_wa = r_b; wk_wd = r_cb;   // restore work[b]
            end
            S_DEC: begin
                // undo: restore both entries, a here, b in S_NEXT
                wk_we = !(r_trial < r_cost && !r_fail && r_load == 21'd0);
                wk_wa = r_a; wk_wd = r_ca;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ovalid <= 1'b0; r_best <= '0; r_pend <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && r_st != S_ORD) r_ovalid <= 1'b0;
            unique case (r_st) inside
                S_IDLE: if (acc && i_data.kind == KIND_START) begin
                    r_len <= (cfg.length > 7'd64) ? 7'd64 : cfg.length;
                    r_i <= '0; r_pend <= 1'b0;
                    if (cfg.length == 7'd0) r_best <= '0;
                    else r_st <= S_COPY;
                end
                S_COPY: begin
                    r_pend <= (r_i < r_len);
                    r_i <= r_i + 7'd1;
                    if (r_i == r_len) begin
                        r_st <= S_CRD; r_i <= '0; r_first <= 1'b1;
                        r_trial <= '0; r_pend <= 1'b0;
                    end
                end
                S_CRD: begin
                    // prev city arrives, then each next city fetches a distance
                    r_pend <= 1'b1;
                    if (r_pend) begin
                        r_prev <= wk_rd;
                        if (r_i > 7'd2) r_trial <= csum[CostW] ? CostMax : csum[CostW-1:0];
                    end
                    if (r_i == r_len) r_st <= S_CWAIT;
                    else r_i <= r_i + 7'd1;
                end
                S_CWAIT: begin
                    // dist for last pair lands now if walk had >1 entry
                    if (r_len > 7'd1)
                        r_trial <= csum[CostW] ? CostMax : csum[CostW-1:0];
                    r_pend <= 1'b0;
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_cost <= (r_len > 7'd1) ? (csum[CostW] ? CostMax : csum[CostW-1:0])
                                                 : '0;
                        r_a <= 6'd1; r_b <= 6'd2;
                        if (r_len < 7'd4) begin
                            r_st <= S_OUT; r_i <= '0;
                        end else begin
                            r_st <= S_SWAPA; r_i <= 7'd1;
                        end
                    end else begin
                        r_st <= S_LOAD; r_i <= '0; r_load <= '0; r_fail <= 1'b0;
                    end
                end
                S_SWAPA: begin
                    r_i <= {1'b0, r_a};   // wk_ra = b this cycle; a read next via r_i
                    r_st <= S_SWAPB;
                end
                S_SWAPB: begin
                    r_cb <= wk_rd;
                    r_st <= S_SWAPR;
                end
                S_SWAPR: begin
                    r_ca <= wk_rd;
                    r_st <= S_SWAPW;
                end
                S_SWAPW: begin
                    // finish swap: work[b] <= old a, then cost walk
                    r_st <= S_CRD; r_i <= '0; r_trial <= '0; r_pend <= 1'b0;
                end
                S_LOAD: begin
                    // entry i-2 has its depot flag and demand ready
                    if (r_i > 7'd1) begin
                        if (r_cur_dep) r_load <= '0;
                        else begin
                            r_load <= lsum;
                            if (lsum > {1'b0, cfg.capacity}) r_fail <= 1'b1;
                        end
                    end
                    if (r_i != 7'd0) r_cur_dep <= (wk_rd == cfg.depot);
                    if (r_i == r_len) r_st <= S_LEND;
                    else r_i <= r_i + 7'd1;
                end
                S_LEND: begin
                    r_pend <= 1'b0;
                    if (r_cur_dep) r_load <= '0;
                    else begin
                        r_load <= lsum;
                        if (lsum > {1'b0, cfg.capacity}) r_fail <= 1'b1;
                    end
                    r_st <= S_DEC;
                end
                S_DEC: begin
                    if (r_trial < r_cost && !r_fail && r_load == 21'd0) begin
                        r_cost <= r_trial;
                        r_st <= S_KEEP;
                    end else begin
                        r_st <= S_NEXT;
                    end
                end
                S_NEXT, S_KEEP: begin
                    if ({1'b0, r_b} + 7'd2 < r_len) r_b <= r_b + 6'd1;
                    else begin
                        r_a <= r_a + 6'd1; r_b <= r_a + 6'd2;
                    end
                    if ({1'b0, r_b} + 7'd2 >= r_len && {1'b0, r_a} + 7'd3 >= r_len) begin
                        r_st <= S_OUT; r_i <= '0;
                    end else r_st <= S_SWAPA;
                end
                S_OUT: begin
                    r_best <= r_cost;
                    r_st <= S_ORD;
                end
                S_ORD: if (!r_ovalid || !i_stall) begin
                    r_ovalid <= 1'b1;
                    r_odata <= '{position: r_i[5:0], city: wk_rd, total_cost: r_best,
                                 last: (r_i == lastpos)};
                    r_i <= r_i + 7'd1;
                    r_st <= (r_i == lastpos) ? S_IDLE : S_OUT;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `CHK_IMPL(a_stall_busy, i_clk, i_rst_n, r_st != S_IDLE, o_stall)
    `CHK_NEXT(a_hold_out, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `CHK_IMPL(a_swap_order, i_clk, i_rst_n, r_st == S_SWAPA, r_a < r_b)
endmodule

/* test/vrp_route_checker.sv */
// Checker for the route swap search: tracks loads and register writes,
// predicts the improved route on every start and compares each output transfer.
// Depends on vrp_pkg.
`timescale 1ns / 100ps
module vrp_route_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  vrp_pkg::t_in_item  i_data,
    input  logic               o_valid,
    input  logic               i_stall,
    input  vrp_pkg::t_out_item o_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);
    import vrp_pkg::*;

    logic [15:0] dist_mem   [MaxCities][MaxCities];
    logic [15:0] demand_mem [MaxCities];
    logic [5:0]  route_mem  [MaxRoute];
    logic [5:0]  work_route [MaxRoute];
    logic [19:0] cap_reg;
    logic [6:0]  len_reg;
    logic [5:0]  depot_reg;
    t_out_item   route_q [$];

    function automatic logic [23:0] work_cost(input int n);
        int unsigned sum;
        sum = 0;
        for (int i = 0; i + 1 < n; i++) begin
            sum += dist_mem[work_route[i]][work_route[i+1]];
            if (sum > CostMax) sum = CostMax;
        end
        return sum[23:0];
    endfunction

    function automatic bit tours_fit(input int n);
        longint unsigned load;
        load = 0;
        for (int i = 0; i < n; i++) begin
            if (work_route[i] != depot_reg) load += demand_mem[work_route[i]];
            else load = 0;
            if (load > cap_reg) return 1'b0;
        end
        return load == 0;
    endfunction

    // Greedy first-improvement swap search; push one expected entry per position.
    task automatic predict_route();
        int n;
        logic [23:0] cost, trial;
        logic [5:0] t;
        t_out_item e;
        n = (len_reg > MaxRoute) ? MaxRoute : len_reg;
        for (int i = 0; i < MaxRoute; i++) work_route[i] = route_mem[i];
        cost = work_cost(n);
        for (int a = 1; a + 1 < n; a++) begin
            for (int b = a + 1; b + 1 < n; b++) begin
                t = work_route[a]; work_route[a] = work_route[b]; work_route[b] = t;
                trial = work_cost(n);
                if (trial < cost && tours_fit(n)) begin
                    cost = trial;
                end else begin
                    t = work_route[a]; work_route[a] = work_route[b]; work_route[b] = t;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            e.position   = i[5:0];
            e.city       = work_route[i];
            e.total_cost = cost;
            e.last       = (i + 1 == n);
            route_q.push_back(e);
        end
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        o_pending = 0;
        cap_reg = '0;
        len_reg = '0;
        depot_reg = '0;
    end

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            cap_reg = '0;
            len_reg = '0;
            depot_reg = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_CAP:   cap_reg   = pwdata[19:0];
                    REG_LEN:   len_reg   = pwdata[6:0];
                    REG_DEPOT: depot_reg = pwdata[5:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                case (i_data.kind)
                    KIND_DIST:
                        dist_mem[i_data.first_index][i_data.second_index] = i_data.value;
                    KIND_DEM:   demand_mem[i_data.first_index] = i_data.value;
                    KIND_ROUTE: route_mem[i_data.first_index] = i_data.value[5:0];
                    KIND_START: predict_route();
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                o_results++;
                if (route_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected output transfer %p", $realtime, o_data);
                end else begin
                    e = route_q.pop_front();
                    if (o_data !== e) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"%0t: mismatch pos/city/cost/last ",
                                      "exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d"},
                                $realtime, e.position, e.city, e.total_cost, e.last,
                                o_data.position, o_data.city, o_data.total_cost,
                                o_data.last);
                    end
                end
            end
            o_pending = route_q.size();
        end
    end
endmodule

/* test/tb_vrp_swap_local_search.sv */
// Top of the route swap search testbench: clock, reset, stimulus and verdict.
// Depends on vrp_pkg, vrp_swap_local_search and vrp_route_checker.
`timescale 1ns / 100ps
module tb_vrp_swap_local_search;
    import vrp_pkg::*;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall, o_valid, i_stall;
    t_in_item    i_data;
    t_out_item   o_data;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          errors, pending, results;
    int          burst_left, sent, phases, starts;
    logic [5:0]  city_set [8];
    int          set_size;

    vrp_swap_local_search u_dut (.*);

    vrp_route_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data, .o_valid, .i_stall, .o_data,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Receiver stall pattern: periodically pick one of three modes (none, random, periodic).
    int stall_mode, stall_cnt;
    initial begin
        i_stall = 1'b0;
        stall_mode = 0;
        stall_cnt = 0;
        forever begin
            @(negedge i_clk);
            stall_cnt++;
            if (stall_cnt % 256 == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: i_stall = 1'b0;
                1: i_stall = ($urandom_range(0, 9) < 3);
                default: i_stall = (stall_cnt % 16) < 5;
            endcase
        end
    end

    initial begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic put(input logic [1:0] kind, input logic [5:0] fi,
                       input logic [5:0] si, input logic [15:0] v);
        @(negedge i_clk);
        if (burst_left <= 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        i_valid = 1'b1;
        i_data = '{kind: kind, first_index: fi, second_index: si, value: v};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        sent++;
        if (kind == KIND_START) starts++;
    endtask

    // Hold the sender until every expected route entry has arrived.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic configure(input int cap, input int len, input logic [5:0] depot);
        drain();
        reg_write(REG_CAP, cap);
        reg_write(REG_LEN, len);
        reg_write(REG_DEPOT, {26'd0, depot});
        phases++;
    endtask

    // Pick a city set with the depot first, then load every distance among it and each city's demand.
    task automatic load_map(input int k, input logic [5:0] depot, input int dmax,
                            input int demand_max);
        logic [5:0] c;
        bit dup;
        set_size = k;
        city_set[0] = depot;
        for (int i = 1; i < k; i++) begin
            do begin
                c = 6'($urandom_range(0, 63));
                dup = 0;
                for (int j = 0; j < i; j++) if (city_set[j] == c) dup = 1;
            end while (dup);
            city_set[i] = c;
        end
        for (int i = 0; i < k; i++)
            for (int j = 0; j < k; j++)
                put(KIND_DIST, city_set[i], city_set[j],
                    ($urandom_range(0, 15) == 0) ? 16'hFFFF
                                                 : 16'($urandom_range(0, dmax)));
        for (int i = 0; i < k; i++)
            put(KIND_DEM, city_set[i], 6'($urandom), 16'($urandom_range(0, demand_max)));
    endtask

    task automatic load_route(input int len, input bit tidy);
        int n;
        logic [5:0] c;
        n = (len > MaxRoute) ? MaxRoute : len;
        for (int p = 0; p < n; p++) begin
            if (p == 0 || ((p == n - 1) && tidy) || $urandom_range(0, 4) == 0) c = city_set[0];
            else c = city_set[$urandom_range(0, set_size - 1)];
            put(KIND_ROUTE, 6'(p), 6'($urandom), {10'($urandom_range(0, 1023)), c});
        end
    endtask

    int k, len, cap;
    logic [5:0] depot;

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        burst_left = 0; sent = 0; phases = 0; starts = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty route: a start gives nothing.
        configure(0, 0, 6'd0);
        put(KIND_START, 6'd0, 6'd0, 16'd0);
        // Extreme indices and values, depot at the top city, full capacity.
        configure(20'hFFFFF, 4, 6'd63);
        load_map(3, 6'd63, 65535, 65535);
        put(KIND_DIST, 6'd63, 6'd63, 16'hFFFF);
        put(KIND_DIST, 6'd0, 6'd0, 16'h0000);
        put(KIND_DEM, 6'd63, 6'd63, 16'hFFFF);
        load_route(4, 1'b1);
        put(KIND_START, 6'd63, 6'd63, 16'hFFFF);
        put(KIND_START, 6'd0, 6'd0, 16'd0);
        // Zero capacity, then routes of one and two entries.
        configure(0, 6, 6'd63);
        load_route(6, 1'b1);
        put(KIND_START, 6'd0, 6'd0, 16'd0);
        configure(12345, 1, 6'd63);
        put(KIND_START, 6'd0, 6'd0, 16'd0);
        configure(12345, 2, 6'd63);
        put(KIND_START, 6'd0, 6'd0, 16'd0);
        // Length above the route store: treated as the full 64 entries.
        configure(20'hFFFFF, 127, 6'd0);
        load_map(3, 6'd0, 300, 50);
        load_route(64, 1'b1);
        put(KIND_START, 6'd0, 6'd0, 16'd0);

        while (sent < 120) begin
            k = $urandom_range(3, 4);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
            cap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20'hFFFFF)
                                            : $urandom_range(20, 200);
            depot = 6'($urandom_range(0, 63));
            configure(cap, len, depot);
            load_map(k, depot, $urandom_range(10, 2000), $urandom_range(0, 120));
            load_route(len, $urandom_range(0, 3) != 0);
            repeat ($urandom_range(0, 3))
                put(KIND_ROUTE, 6'($urandom_range(len < 63 ? len : 63, 63)), 6'd0,
                    16'($urandom));
            put(KIND_START, 6'($urandom), 6'($urandom), 16'($urandom));
            if ($urandom_range(0, 2) == 0) begin
                put(KIND_DEM, city_set[$urandom_range(0, k - 1)], 6'd0,
                    16'($urandom_range(0, 60)));
                put(KIND_START, 6'd0, 6'd0, 16'd0);
            end
        end
        drain();

        $display("covered %0d register phases, %0d input transfers, %0d searches",
            phases, sent, starts);
        $display("checked %0d route entries, %0d mismatches", results, errors);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
